/* hdl/six_channel_moving_average_assert.svh */
// assertion macros used by the checker file
`ifndef SIX_CHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define SIX_CHANNEL_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SCMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scma check failed");

// next-cycle implication, disabled during reset
`define SCMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scma check failed");

`endif

/* hdl/scma_pkg.sv */
package scma_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CHANNELS    = 6;
    localparam int WS_BITS     = 4;

    localparam logic [WS_BITS-1:0] RESET_WINDOW = 4'd5;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0] sample_vec_t;

    typedef struct packed {
        sample_t voltage_a;
        sample_t voltage_b;
        sample_t voltage_c;
        sample_t current_a;
        sample_t current_b;
        sample_t current_c;
    } sample_in_t;

    typedef struct packed {
        sample_t mean_voltage_a;
        sample_t mean_voltage_b;
        sample_t mean_voltage_c;
        sample_t mean_current_a;
        sample_t mean_current_b;
        sample_t mean_current_c;
    } mean_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hdl/six_channel_moving_average.sv */
// Six-channel moving average of phase voltage and current samples.
// Input channel s_valid/s_ready/s_word carries one word of six unsigned
// samples; it is written into a window ring at the shared write position.
// Result channel m_valid/m_ready/m_word carries the six rounded means of
// the stored entries (warm-up: only the entries written so far).
// Config channel cfg_valid/cfg_ready/cfg_window_size sets the window size;
// values of 0 or above MAX_WINDOW are ignored. cfg_ready is always high.
// After an input word is accepted, the block reads the N averaged entries
// (at most MAX_WINDOW) from the ring, one ring read per cycle, into the
// sums, drains the read register, and runs a restoring divider over the
// S-bit sums (S is 20 bits at the default MAX_WINDOW of 10), which produces
// one quotient bit per cycle; then it loads the result. No new word is taken
// until the result is loaded into the output register.
// Reset (aresetn low, synchronous) empties the window, sets the write
// position to zero and the window size to 5.
// A stalled receiver holds the result in the output register; the block
// still takes and works on the next word, then waits before delivering it.
module six_channel_moving_average #(
    parameter int MAX_WINDOW = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  scma_pkg::sample_in_t                s_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output scma_pkg::mean_out_t                 m_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scma_pkg::WS_BITS-1:0]        cfg_window_size
);
    import scma_pkg::*;

    localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int CW        = (CNT_BITS > WS_BITS) ? CNT_BITS : WS_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int STEP_BITS = $clog2(SUM_BITS);

    state_t state_reg, state_next;

    logic [WS_BITS-1:0]   ws_reg;
    logic [CW-1:0]        pos_reg;
    logic                 full_reg;

    sample_in_t           mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] vld_reg;
    sample_in_t           rd_data_reg;
    logic                 rd_vld_reg;
    logic                 rd_pend_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [AW-1:0]        last_idx_reg;

    logic [CW-1:0]        div_reg;
    logic [SUM_BITS-1:0]  sum_reg [CHANNELS];
    logic [CW-1:0]        rem_reg [CHANNELS];
    logic [STEP_BITS-1:0] step_reg;

    mean_out_t            m_word_reg;
    logic                 m_valid_reg;

    // control
    logic                 accept;
    logic                 issue;
    logic                 div_en;
    logic                 load_out;
    logic                 cfg_ok;

    // write position and count for the incoming word
    logic [AW-1:0]        wr_addr;
    logic [CW-1:0]        pos_inc;
    logic [CW-1:0]        ws_ext;
    logic                 pos_wrap;
    logic [CW-1:0]        count;
    logic [CW-1:0]        nread;

    // datapath
    sample_vec_t          rd_sample;
    sample_vec_t          quot;
    logic [CW:0]          trial    [CHANNELS];
    logic                 ge       [CHANNELS];
    logic [CW-1:0]        rem_next [CHANNELS];
    logic [SUM_BITS-1:0]  sum_next [CHANNELS];

    assign cfg_ready = 1'b1;
    assign cfg_ok    = cfg_valid && (cfg_window_size != '0)
                       && (CW'(cfg_window_size) <= CW'(MAX_WINDOW));

    always_comb begin
        wr_addr  = (pos_reg >= CW'(MAX_WINDOW)) ? '0 : pos_reg[AW-1:0];
        pos_inc  = CW'(wr_addr) + CW'(1);
        ws_ext   = CW'(ws_reg);
        pos_wrap = pos_inc >= ws_ext;
        count    = (full_reg || pos_wrap) ? ws_ext : pos_inc;
        nread    = (count > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : count;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (rd_idx_reg == last_idx_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        div_en   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_READ:  issue    = 1'b1;
            ST_DRAIN: ;
            ST_DIV:   div_en   = 1'b1;
            ST_DONE:  load_out = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ws_reg      <= RESET_WINDOW;
            pos_reg     <= '0;
            full_reg    <= 1'b0;
            vld_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
            if (cfg_ok) begin
                ws_reg <= cfg_window_size;
            end
            if (accept) begin
                pos_reg           <= pos_wrap ? '0 : pos_inc;
                full_reg          <= full_reg || pos_wrap;
                vld_reg[wr_addr]  <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window ring
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[wr_addr] <= s_word;
        end
        rd_data_reg <= mem[rd_idx_reg];
        rd_vld_reg  <= vld_reg[rd_idx_reg];
    end

    assign rd_sample = sample_vec_t'(rd_data_reg);

    // one restoring division step per channel
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            trial[ch]    = {rem_reg[ch], sum_reg[ch][SUM_BITS-1]};
            ge[ch]       = trial[ch] >= {1'b0, div_reg};
            rem_next[ch] = ge[ch] ? CW'(trial[ch] - {1'b0, div_reg}) : trial[ch][CW-1:0];
            sum_next[ch] = {sum_reg[ch][SUM_BITS-2:0], ge[ch]};
            quot[ch]     = sum_reg[ch][SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_idx_reg   <= '0;
            last_idx_reg <= AW'(nread - CW'(1));
            div_reg      <= count;
            step_reg     <= STEP_BITS'(SUM_BITS - 1);
        end else begin
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
            if (div_en) begin
                step_reg <= step_reg - STEP_BITS'(1);
            end
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (accept) begin
                // rounding offset of half the divisor
                sum_reg[ch] <= SUM_BITS'(count >> 1);
                rem_reg[ch] <= '0;
            end else if (rd_pend_reg) begin
                sum_reg[ch] <= sum_reg[ch]
                               + (rd_vld_reg ? SUM_BITS'(rd_sample[ch]) : '0);
            end else if (div_en) begin
                sum_reg[ch] <= sum_next[ch];
                rem_reg[ch] <= rem_next[ch];
            end
        end
        if (load_out) begin
            m_word_reg <= mean_out_t'(quot);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

/* hdl/scma_checker.sv */
`include "six_channel_moving_average_assert.svh"

module scma_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  scma_pkg::mean_out_t  m_word
);

    // a stalled result word holds
    `SCMA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word))

    // one word in work at a time
    `SCMA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // a result never appears right after an input word is taken
    `SCMA_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready, !$rose(m_valid))

    // a new result is loaded only at the end of a computation
    `SCMA_ASSERT_NOW(a_result_from_work, $rose(m_valid), $past(!s_ready))

endmodule

bind six_channel_moving_average scma_checker u_scma_checker (.*);
